FILE: src/dhot_pkg.sv
// Shared types, codes and constants for the double-hash open-address table.
`timescale 1ns / 1ps

package dhot_pkg;

    // Fixed field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 11;
    localparam int HINT_W  = 31;
    localparam int REM_W   = CFG_W + 1;
    localparam int PROD_W  = 62;
    localparam int DIV_CW  = 6;

    // Hash multipliers
    localparam logic [31:0] HASH_MUL1 = 32'd2654435761;
    localparam logic [23:0] HASH_MUL2 = 24'd13845163;
    localparam logic [HINT_W-1:0] HINT_MAX = 31'd2147483647;
    localparam logic [CFG_W-1:0] CNT_MAX = 11'd2047;

    // Request operations; the spare code behaves as a get
    localparam logic [1:0] FN_GET    = 2'd0;
    localparam logic [1:0] FN_PUT    = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;
    localparam logic [1:0] FN_SPARE  = 2'd3;

    // Result status codes
    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_MISS = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_BUSY     = 2'd1;
    localparam logic [1:0] REG_DENSE    = 2'd2;
    localparam logic [1:0] REG_SPARSE   = 2'd3;

    // Slot states
    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_USED = 2'd1;
    localparam logic [1:0] SLOT_DEAD = 2'd2;

    // Hint selection
    localparam logic [1:0] HSEL_NONE = 2'd0;
    localparam logic [1:0] HSEL_CAP  = 2'd1;
    localparam logic [1:0] HSEL_ROM  = 2'd2;

    // Prime size ROM
    localparam int ROM_N = 37;
    localparam logic [HINT_W-1:0] SIZE_ROM [ROM_N] = '{
        31'd7, 31'd13, 31'd29, 31'd59, 31'd113, 31'd223, 31'd431, 31'd821,
        31'd1567, 31'd2999, 31'd5701, 31'd10837, 31'd20593, 31'd39133,
        31'd74353, 31'd141277, 31'd268439, 31'd510047, 31'd969097,
        31'd1841291, 31'd3498457, 31'd5247701, 31'd7871573, 31'd11807381,
        31'd17711087, 31'd26566649, 31'd39849977, 31'd59774983,
        31'd89662483, 31'd134493731, 31'd201740597, 31'd302610937,
        31'd453916423, 31'd680874641, 31'd1021311983, 31'd1531968019,
        31'd2147483647
    };

    // One stored slot
    typedef struct packed {
        logic [1:0]       st;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } slot_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic seed;
        logic rd;
        logic step;
        logic fin;
        logic fail;
        logic hnum;
        logic hlook;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic div_last;
        logic term;
        logic wrap;
    } sts_t;

    // Smallest ROM prime above n, saturating
    function automatic logic [HINT_W-1:0] next_size(input logic [REM_W-1:0] n);
        logic [HINT_W-1:0] r;
        r = HINT_MAX;
        for (int i = ROM_N - 1; i >= 0; i--) begin
            if (SIZE_ROM[i] > HINT_W'(n)) begin
                r = SIZE_ROM[i];
            end
        end
        return r;
    endfunction

endpackage

FILE: src/double_hash_open_address_table.sv
// Top level of the double-hash open-address key/value table.
// Each request runs a bit-serial modulo of both hash products by the capacity, then a
// probe walk that reads and checks slots until it ends or wraps round full.
// One item at a time; the next is taken once the result is loaded and the sequencer is idle.
// Reset: registers to defaults, counts zero, then a clear sweep over all TABLE_SLOTS
// slots marks every slot free; no item is accepted during that sweep.
`timescale 1ns / 1ps

module double_hash_open_address_table #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]   s_axis_tuser,   // func[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // read_value[31:0], resize_hint[62:32], 0[63]
    output logic [1:0]   m_axis_tuser,   // status[1:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    dhot_pkg::cmd_t cmd;
    dhot_pkg::sts_t sts;
    logic [dhot_pkg::VAL_W-1:0]  out_value;
    logic [dhot_pkg::HINT_W-1:0] out_hint;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {1'b0, out_hint, out_value};

    // Sequencer
    dhot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath and slot store
    dhot_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_func    (s_axis_tuser),
        .in_key     (s_axis_tdata[31:0]),
        .in_value   (s_axis_tdata[63:32]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (m_axis_tuser),
        .out_value  (out_value),
        .out_hint   (out_hint)
    );

endmodule

FILE: src/dhot_ctrl.sv
// Sequencing state machine for the double-hash table.
`timescale 1ns / 1ps

module dhot_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  dhot_pkg::sts_t    sts,
    output dhot_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_DIV, S_SEED, S_RD, S_CHK,
        S_FIN, S_FAIL, S_HNUM, S_HLOOK, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = S_SEED;
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (sts.term) state_next = S_FIN;
                else if (sts.wrap) state_next = S_FAIL;
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_HNUM;
            end
            S_FAIL:
            begin
                cmd.fail   = 1'b1;
                state_next = S_OUT;
            end
            S_HNUM:
            begin
                cmd.hnum   = 1'b1;
                state_next = S_HLOOK;
            end
            S_HLOOK:
            begin
                cmd.hlook  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // No item taken before the slot store is cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> sts.clr_done)
        else $error("item accepted during clear pass");

    // A result load always shows up as a valid result
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load lost");

    // Every slot check follows a slot read
    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> ($past(state_reg) == S_RD))
        else $error("slot check without read");

endmodule

FILE: src/dhot_dp.sv
// Datapath: config registers, hashing divider, slot memory, counters, result.
`timescale 1ns / 1ps

module dhot_dp #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [dhot_pkg::CFG_W-1:0]    cfg_data,
    input  logic [1:0]                    in_func,
    input  logic [dhot_pkg::KEY_W-1:0]    in_key,
    input  logic [dhot_pkg::VAL_W-1:0]    in_value,
    input  dhot_pkg::cmd_t                cmd,
    output dhot_pkg::sts_t                sts,
    output logic [1:0]                    out_status,
    output logic [dhot_pkg::VAL_W-1:0]    out_value,
    output logic [dhot_pkg::HINT_W-1:0]   out_hint
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = dhot_pkg::CFG_W;
    localparam int RW = dhot_pkg::REM_W;
    localparam int PW = dhot_pkg::PROD_W;

    // Configuration registers
    logic [CW-1:0] capacity_reg, busy_reg, dense_reg, sparse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CW'(7);
            busy_reg     <= CW'(5);
            dense_reg    <= CW'(4);
            sparse_reg   <= CW'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dhot_pkg::REG_CAPACITY: capacity_reg <= cfg_data;
                dhot_pkg::REG_BUSY:     busy_reg     <= cfg_data;
                dhot_pkg::REG_DENSE:    dense_reg    <= cfg_data;
                dhot_pkg::REG_SPARSE:   sparse_reg   <= cfg_data;
                default:                capacity_reg <= capacity_reg;
            endcase
        end
    end

    // Effective capacity, clamped to 1..TABLE_SLOTS
    logic [CW-1:0] cap0, cap;
    assign cap0 = (capacity_reg == '0) ? CW'(1) : capacity_reg;
    assign cap  = (32'(cap0) > 32'(TABLE_SLOTS)) ? CW'(TABLE_SLOTS) : cap0;

    // Captured request
    logic [1:0]                 func_reg;
    logic [dhot_pkg::KEY_W-1:0] key_reg;
    logic [dhot_pkg::VAL_W-1:0] val_reg;
    logic                       is_put, is_rem;

    assign is_put = (func_reg == dhot_pkg::FN_PUT);
    assign is_rem = (func_reg == dhot_pkg::FN_REMOVE);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            key_reg  <= in_key;
            val_reg  <= in_value;
        end
    end

    // Hash products, then restoring division by the capacity, one bit a cycle
    logic [28:0]               k_hi;
    logic [60:0]               m1;
    logic [52:0]               m2;
    logic [PW-1:0]             p1_reg, p2_reg;
    logic [CW-1:0]             r1_reg, r2_reg;
    logic [dhot_pkg::DIV_CW-1:0] div_cnt_reg;
    logic [RW-1:0]             r1_sh, r2_sh;
    logic [CW-1:0]             r1_next, r2_next;

    assign k_hi  = key_reg[dhot_pkg::KEY_W-1:3];
    assign m1    = k_hi * dhot_pkg::HASH_MUL1;
    assign m2    = k_hi * dhot_pkg::HASH_MUL2;
    assign r1_sh = {r1_reg, p1_reg[PW-1]};
    assign r2_sh = {r2_reg, p2_reg[PW-1]};
    assign r1_next = (r1_sh >= RW'(cap)) ? CW'(r1_sh - RW'(cap)) : CW'(r1_sh);
    assign r2_next = (r2_sh >= RW'(cap)) ? CW'(r2_sh - RW'(cap)) : CW'(r2_sh);
    assign sts.div_last = (div_cnt_reg == dhot_pkg::DIV_CW'(PW - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p1_reg      <= PW'(m1) + PW'(key_reg[2:0]);
            p2_reg      <= PW'(m2);
            r1_reg      <= '0;
            r2_reg      <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            p1_reg      <= {p1_reg[PW-2:0], 1'b0};
            p2_reg      <= {p2_reg[PW-2:0], 1'b0};
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Probe index
    logic [CW-1:0] h1_reg, h2_reg, idx_reg, idx_next;
    logic [RW-1:0] idx_sum;

    assign idx_sum  = RW'(idx_reg) + RW'(h2_reg);
    assign idx_next = (idx_sum >= RW'(cap)) ? CW'(idx_sum - RW'(cap)) : CW'(idx_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.seed)
        begin
            h1_reg  <= r1_reg;
            h2_reg  <= (r2_reg == '0) ? CW'(1) : r2_reg;
            idx_reg <= r1_reg;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_next;
        end
    end

    // Clear sweep after reset
    logic [IW:0] clr_cnt_reg;
    logic        clr_done;

    assign clr_done     = (clr_cnt_reg == (IW+1)'(TABLE_SLOTS));
    assign sts.clr_done = clr_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)         clr_cnt_reg <= '0;
        else if (!clr_done) clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Slot memory
    dhot_pkg::slot_word_t mem [TABLE_SLOTS];
    dhot_pkg::slot_word_t rd_reg, wr_word;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic                 match;

    assign match = (rd_reg.st == dhot_pkg::SLOT_USED) && (rd_reg.key == key_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = IW'(idx_reg);
        wr_word = '0;
        priority if (!clr_done)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg[IW-1:0];
        end
        else if (cmd.fin && is_put)
        begin
            wr_en   = 1'b1;
            wr_word = '{st: dhot_pkg::SLOT_USED, key: key_reg, val: val_reg};
        end
        else if (cmd.fin && is_rem && match)
        begin
            wr_en   = 1'b1;
            wr_word = '{st: dhot_pkg::SLOT_DEAD, key: key_reg, val: '0};
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_word;
        if (cmd.rd) rd_reg <= mem[IW'(idx_reg)];
    end

    // Walk decisions
    assign sts.term = is_put ? (rd_reg.st == dhot_pkg::SLOT_FREE ||
                                rd_reg.st == dhot_pkg::SLOT_DEAD || match)
                             : (match || rd_reg.st == dhot_pkg::SLOT_FREE);
    assign sts.wrap = (idx_next == h1_reg);

    // Counters
    logic [CW-1:0] live_reg, used_reg, live_inc, used_inc;

    assign live_inc = (live_reg != dhot_pkg::CNT_MAX) ? live_reg + 1'b1 : live_reg;
    assign used_inc = (used_reg != dhot_pkg::CNT_MAX) ? used_reg + 1'b1 : used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            used_reg <= '0;
        end
        else if (cmd.fin)
        begin
            if (is_put && rd_reg.st == dhot_pkg::SLOT_FREE)
            begin
                live_reg <= live_inc;
                used_reg <= used_inc;
            end
            else if (is_put && rd_reg.st == dhot_pkg::SLOT_DEAD)
            begin
                live_reg <= live_inc;
            end
            else if (is_rem && match && live_reg != '0)
            begin
                live_reg <= live_reg - 1'b1;
            end
        end
    end

    // Result and hint
    logic [1:0]                  res_status_reg;
    logic [dhot_pkg::VAL_W-1:0]  res_value_reg;
    logic [dhot_pkg::HINT_W-1:0] res_hint_reg;
    logic [1:0]                  hmode_reg, hsel_reg;
    logic [RW-1:0]               hn_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            priority if (is_put)
            begin
                res_status_reg <= dhot_pkg::RES_OK;
                res_value_reg  <= '0;
                hmode_reg      <= dhot_pkg::HSEL_CAP;
            end
            else if (match)
            begin
                res_status_reg <= dhot_pkg::RES_OK;
                if (is_rem)
                begin
                    res_value_reg <= '0;
                    hmode_reg     <= dhot_pkg::HSEL_ROM;
                end
                else
                begin
                    res_value_reg <= rd_reg.val;
                    hmode_reg     <= dhot_pkg::HSEL_NONE;
                end
            end
            else
            begin
                res_status_reg <= dhot_pkg::RES_MISS;
                res_value_reg  <= '0;
                hmode_reg      <= dhot_pkg::HSEL_NONE;
            end
        end
        else if (cmd.fail)
        begin
            res_status_reg <= dhot_pkg::RES_FULL;
            res_value_reg  <= '0;
            res_hint_reg   <= '0;
        end
        else if (cmd.hnum)
        begin
            priority if (hmode_reg == dhot_pkg::HSEL_CAP && used_reg >= busy_reg)
            begin
                hsel_reg <= (live_reg < dense_reg) ? dhot_pkg::HSEL_CAP
                                                   : dhot_pkg::HSEL_ROM;
                hn_reg   <= RW'(cap);
            end
            else if (hmode_reg == dhot_pkg::HSEL_ROM && live_reg < sparse_reg)
            begin
                hsel_reg <= dhot_pkg::HSEL_ROM;
                hn_reg   <= RW'(live_reg) + RW'(live_reg >> 1) + RW'(live_reg >> 2);
            end
            else
            begin
                hsel_reg <= dhot_pkg::HSEL_NONE;
                hn_reg   <= RW'(cap);
            end
        end
        else if (cmd.hlook)
        begin
            unique case (hsel_reg)
                dhot_pkg::HSEL_CAP: res_hint_reg <= dhot_pkg::HINT_W'(cap);
                dhot_pkg::HSEL_ROM: res_hint_reg <= dhot_pkg::next_size(hn_reg);
                default:            res_hint_reg <= '0;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status <= res_status_reg;
            out_value  <= res_value_reg;
            out_hint   <= res_hint_reg;
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the double-hash open-address key/value table.
`timescale 1ns / 1ps

module testbench;

    // Shadow copy of the table: predicts each result and checks it on arrival
    class table_shadow;
        bit [1:0]        slot_st [1024];
        bit [31:0]       slot_k [1024];
        bit [31:0]       slot_v [1024];
        int unsigned     live_cnt;
        int unsigned     used_cnt;
        int unsigned     cap_reg;
        int unsigned     busy_reg;
        int unsigned     dense_reg;
        int unsigned     sparse_reg;
        bit [64:0]       pending_results[$];   // {status, read_value, hint}
        int              errors;

        function new();
            foreach (slot_st[i]) slot_st[i] = dhot_pkg::SLOT_FREE;
            live_cnt = 0;
            used_cnt = 0;
            cap_reg = 7;
            busy_reg = 5;
            dense_reg = 4;
            sparse_reg = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [10:0] data);
            case (idx)
                dhot_pkg::REG_CAPACITY: cap_reg = data;
                dhot_pkg::REG_BUSY:     busy_reg = data;
                dhot_pkg::REG_DENSE:    dense_reg = data;
                default:                sparse_reg = data;
            endcase
        endfunction

        function int unsigned prime_above(int unsigned n);
            for (int i = 0; i < dhot_pkg::ROM_N; i++)
                if (dhot_pkg::SIZE_ROM[i] > n) return dhot_pkg::SIZE_ROM[i];
            return dhot_pkg::HINT_MAX;
        endfunction

        function int unsigned bump(int unsigned c);
            return (c < dhot_pkg::CNT_MAX) ? c + 1 : dhot_pkg::CNT_MAX;
        endfunction

        // Walk the probe sequence exactly as the block does and queue the result
        function void predict_request(logic [1:0] fn, logic [31:0] key, logic [31:0] val);
            int unsigned cap, start, stride, idx;
            bit [1:0]    status;
            bit [31:0]   rd;
            int unsigned hint;
            bit          hit;
            bit [63:0]   prod;
            cap = cap_reg;
            status = dhot_pkg::RES_FULL;
            rd = 0;
            hint = 0;
            if (cap == 0) cap = 1;
            if (cap > 1024) cap = 1024;
            prod = 64'(key >> 3) * 64'd2654435761 + 64'(key & 32'd7);
            start = 32'(prod % 64'(cap));
            prod = 64'(key >> 3) * 64'd13845163;
            stride = 32'(prod % 64'(cap));
            if (stride == 0) stride = 1;
            idx = start;
            do begin
                hit = (slot_st[idx] == dhot_pkg::SLOT_USED) && (slot_k[idx] == key);
                if (fn == dhot_pkg::FN_PUT) begin
                    if (slot_st[idx] != dhot_pkg::SLOT_USED || hit) begin
                        if (slot_st[idx] == dhot_pkg::SLOT_FREE) begin
                            live_cnt = bump(live_cnt);
                            used_cnt = bump(used_cnt);
                        end else if (slot_st[idx] == dhot_pkg::SLOT_DEAD) begin
                            live_cnt = bump(live_cnt);
                        end
                        slot_st[idx] = dhot_pkg::SLOT_USED;
                        slot_k[idx] = key;
                        slot_v[idx] = val;
                        status = dhot_pkg::RES_OK;
                        if (used_cnt < busy_reg) hint = 0;
                        else if (live_cnt < dense_reg) hint = cap;
                        else hint = prime_above(cap);
                        break;
                    end
                end else if (fn == dhot_pkg::FN_REMOVE) begin
                    if (hit) begin
                        slot_st[idx] = dhot_pkg::SLOT_DEAD;
                        slot_v[idx] = 0;
                        if (live_cnt > 0) live_cnt--;
                        status = dhot_pkg::RES_OK;
                        if (live_cnt < sparse_reg)
                            hint = prime_above(live_cnt + (live_cnt >> 1) + (live_cnt >> 2));
                        break;
                    end
                    if (slot_st[idx] == dhot_pkg::SLOT_FREE) begin
                        status = dhot_pkg::RES_MISS;
                        break;
                    end
                end else begin
                    // get, and the unused code that acts as a get
                    if (hit) begin
                        status = dhot_pkg::RES_OK;
                        rd = slot_v[idx];
                        break;
                    end
                    if (slot_st[idx] == dhot_pkg::SLOT_FREE) begin
                        status = dhot_pkg::RES_MISS;
                        break;
                    end
                end
                idx += stride;
                if (idx >= cap) idx -= cap;
            end while (idx != start);
            pending_results.push_back({status, rd, 31'(hint)});
        endfunction

        task report(string what);
            $display("tb: mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [1:0] status, logic [31:0] rd, logic [30:0] hint);
            bit [64:0] want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result status=%0d", status));
                return;
            end
            want = pending_results.pop_front();
            if (status !== want[64:63])
                report($sformatf("status %0d, want %0d", status, want[64:63]));
            if (rd !== want[62:31])
                report($sformatf("read_value %h, want %h", rd, want[62:31]));
            if (hint !== want[30:0])
                report($sformatf("resize_hint %0d, want %0d", hint, want[30:0]));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    logic [31:0] key_pool[24];
    table_shadow shadow = new();

    double_hash_open_address_table i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Accepted requests feed the predictor, accepted results are checked
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            shadow.predict_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[62:32]);
    end

    task send_request(logic [1:0] fn, logic [31:0] key, logic [31:0] val);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {val, key};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (shadow.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow.set_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task set_config(int unsigned cap, int unsigned busy, int unsigned dense,
                    int unsigned sparse);
        write_reg(dhot_pkg::REG_CAPACITY, 11'(cap));
        write_reg(dhot_pkg::REG_BUSY, 11'(busy));
        write_reg(dhot_pkg::REG_DENSE, 11'(dense));
        write_reg(dhot_pkg::REG_SPARSE, 11'(sparse));
        @(posedge clk);
    endtask

    // Random traffic over a small key set so hits, tombstones and full walks occur
    task random_burst(int n);
        logic [1:0]  fn;
        logic [31:0] key;
        int unsigned roll;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 40) fn = dhot_pkg::FN_PUT;
            else if (roll < 75) fn = dhot_pkg::FN_GET;
            else if (roll < 95) fn = dhot_pkg::FN_REMOVE;
            else fn = dhot_pkg::FN_SPARE;
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)] : $urandom();
            send_request(fn, key, $urandom());
            if (i == n / 2 && $urandom_range(1)) wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles first, receiver stalls often
        send_idle = 18;
        recv_idle = 66;

        // Directed: defaults, capacity 7
        set_config(7, 5, 4, 1);
        send_request(dhot_pkg::FN_PUT, 32'h0, 32'hFFFF_FFFF);
        send_request(dhot_pkg::FN_PUT, 32'hFFFF_FFFF, 32'h0);
        send_request(dhot_pkg::FN_GET, 32'h0, 32'h1234_5678);
        send_request(dhot_pkg::FN_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(dhot_pkg::FN_GET, 32'd5, 32'h0);
        send_request(dhot_pkg::FN_PUT, 32'h0, 32'hA5A5_5A5A);
        send_request(dhot_pkg::FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(dhot_pkg::FN_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(dhot_pkg::FN_SPARE, 32'h0, 32'h0);
        for (int i = 1; i <= 8; i++) send_request(dhot_pkg::FN_PUT, 32'(i * 8), 32'(i));
        send_request(dhot_pkg::FN_GET, 32'd1234, 32'h0);
        send_request(dhot_pkg::FN_REMOVE, 32'd1234, 32'h0);
        send_request(dhot_pkg::FN_REMOVE, 32'd8, 32'h0);
        send_request(dhot_pkg::FN_PUT, 32'd8, 32'h77);
        send_request(dhot_pkg::FN_PUT, 32'd1234, 32'h55);
        wait_drained();

        // Random phases across settings, idling pattern changing per third
        set_config(1024, 0, 0, 0);
        random_burst(280);
        set_config(0, 2047, 2047, 2047);
        random_burst(280);
        send_idle = 66;
        recv_idle = 18;
        set_config(2047, 10, 20, 30);
        random_burst(280);
        set_config(13, 3, 6, 4);
        random_burst(280);
        send_idle = 0;
        recv_idle = 0;
        set_config(59, 40, 30, 10);
        random_burst(280);
        set_config(113, 60, 80, 50);
        random_burst(280);

        repeat (200) @(posedge clk);
        if (shadow.pending_results.size() != 0)
            shadow.report("results still outstanding at end");
        if (shadow.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit
    initial
    begin
        #40000000;
        $display("tb: failure");
        $finish;
    end

endmodule
